// File: src/plane_plane_intersection_line_top_assert.svh
// Assertion macros for the intersection line block
`ifndef PLANE_PLANE_INTERSECTION_LINE_TOP_ASSERT_SVH
`define PLANE_PLANE_INTERSECTION_LINE_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define PPIL_ASSERT_IMPL(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error("ppil check failed");
`define PPIL_ASSERT_NORST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("ppil check failed");
`else
`define PPIL_ASSERT_IMPL(label, clk, rst, prop)
`define PPIL_ASSERT_NORST(label, clk, prop)
`endif
`endif

// File: src/ppil_pkg.sv
`default_nettype none
package ppil_pkg;
  localparam int unsigned STAGES = 4;
  localparam logic [31:0] THRESH_RESET = 32'd429497;
  localparam logic [43:0] COEF_MAX = 44'hFFF_FFFF_FFFF;
  typedef logic [STAGES-1:0] valid_vec_t;
endpackage
`default_nettype wire

// File: src/ppil_recip.sv
`default_nettype none
// floor(2^63 / d), restoring radix-2, one quotient bit per stage, d >= 1
module ppil_recip #(
  parameter int unsigned W = 64
) (
  input  wire logic         clk,
  input  wire logic         en,
  input  wire logic [W-1:0] d,
  output logic [W-1:0]      q
);
  logic [W-1:0] rem [W+1];
  logic [W-1:0] quo [W+1];
  logic [W-1:0] dv  [W+1];

  always_comb begin
    rem[0] = '0;
    quo[0] = '0;
    dv[0]  = d;
  end

  for (genvar i = 0; i < W; i++) begin : g_st
    logic [W:0] tr;
    logic       nb;
    always_comb begin
      nb = (i == 0) ? 1'b1 : 1'b0;
      tr = {rem[i], nb};
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (tr >= {1'b0, dv[i]}) begin
          rem[i+1] <= W'(tr - {1'b0, dv[i]});
          quo[i+1] <= {quo[i][W-2:0], 1'b1};
        end else begin
          rem[i+1] <= tr[W-1:0];
          quo[i+1] <= {quo[i][W-2:0], 1'b0};
        end
        dv[i+1] <= dv[i];
      end
    end
  end

  assign q = quo[W];
endmodule
`default_nettype wire

// File: src/plane_plane_intersection_line_top.sv
`default_nettype none
// Throughput: one word per cycle unless the output stalls.
// The reciprocal is a 64-stage array.
// A stall freezes the whole pipeline; nothing is lost or repeated.
// Reset (rst, synchronous) clears valid bits and sets the threshold to 429497.
`include "plane_plane_intersection_line_top_assert.svh"
module plane_plane_intersection_line_top (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [31:0]  cfg_data,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // n1x[17:0] n1y n1z d1[31:0] n2x n2y n2z d2, zero fill to 176
  input  wire logic [175:0] s_tdata,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // px[31:0] py pz dx[19:0] dy dz, zero fill to 160
  output logic [159:0]      m_tdata,
  // status
  output logic              m_tuser
);
  localparam int unsigned DL = 64;
  localparam int unsigned NS = DL + 10;

  logic [31:0] thr;
  logic        en;
  logic [NS-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) thr <= ppil_pkg::THRESH_RESET;
    else if (cfg_we) thr <= cfg_data;
  end

  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[NS-1];

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[NS-2:0], s_tvalid};
  end

  // stage 1: capture
  logic signed [17:0] a [3], b [3];
  logic signed [31:0] d1, d2;
  always_ff @(posedge clk) begin
    if (en) begin
      a[0] <= s_tdata[17:0];    a[1] <= s_tdata[35:18];   a[2] <= s_tdata[53:36];
      d1   <= s_tdata[85:54];
      b[0] <= s_tdata[103:86];  b[1] <= s_tdata[121:104]; b[2] <= s_tdata[139:122];
      d2   <= s_tdata[171:140];
    end
  end

  // stage 2: products
  logic signed [35:0] pc [6];
  logic signed [35:0] pa [3], pb [3], pab [3];
  logic signed [31:0] d1_2, d2_2;
  always_ff @(posedge clk) begin
    if (en) begin
      pc[0] <= a[1]*b[2]; pc[1] <= a[2]*b[1];
      pc[2] <= a[2]*b[0]; pc[3] <= a[0]*b[2];
      pc[4] <= a[0]*b[1]; pc[5] <= a[1]*b[0];
      for (int i = 0; i < 3; i++) begin
        pa[i] <= a[i]*a[i]; pb[i] <= b[i]*b[i]; pab[i] <= a[i]*b[i];
      end
      d1_2 <= d1; d2_2 <= d2;
    end
  end

  // stage 3: sums
  logic signed [19:0] c3 [3];
  logic signed [21:0] n00, n01, n11;
  logic signed [37:0] s00, s01, s11;
  logic signed [36:0] x0, x1, x2;
  logic signed [31:0] d1_3, d2_3;
  always_comb begin
    x0 = 37'(pc[0]) - 37'(pc[1]);
    x1 = 37'(pc[2]) - 37'(pc[3]);
    x2 = 37'(pc[4]) - 37'(pc[5]);
    s00 = 38'(pa[0]) + 38'(pa[1]) + 38'(pa[2]);
    s01 = 38'(pab[0]) + 38'(pab[1]) + 38'(pab[2]);
    s11 = 38'(pb[0]) + 38'(pb[1]) + 38'(pb[2]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      c3[0] <= x0[35:16]; c3[1] <= x1[35:16]; c3[2] <= x2[35:16];
      n00 <= s00[37:16]; n01 <= s01[37:16]; n11 <= s11[37:16];
      d1_3 <= d1_2; d2_3 <= d2_2;
    end
  end

  // stage 4: squares, det products, numerator products
  logic [39:0] q0, q1, q2;
  logic signed [43:0] m00_11, m01_01;
  logic signed [53:0] t01d2, t11d1, t01d1, t00d2;
  logic signed [19:0] c4 [3];
  always_ff @(posedge clk) begin
    if (en) begin
      q0 <= 40'(c3[0]*c3[0]); q1 <= 40'(c3[1]*c3[1]); q2 <= 40'(c3[2]*c3[2]);
      m00_11 <= n00*n11; m01_01 <= n01*n01;
      t01d2 <= n01*d2_3; t11d1 <= n11*d1_3;
      t01d1 <= n01*d1_3; t00d2 <= n00*d2_3;
      c4 <= c3;
    end
  end

  // stage 5: det, sqr, numerators, status
  logic signed [44:0] dets;
  logic [44:0] detu;
  logic [41:0] sqr;
  logic [54:0] num0, num1;
  logic        neg0, neg1, dneg, none5;
  logic signed [19:0] c5 [3];
  logic signed [54:0] e0, e1;
  logic signed [44:0] dt;
  always_comb begin
    dt = 45'(m00_11) - 45'(m01_01);
    e0 = 55'(t01d2) - 55'(t11d1);
    e1 = 55'(t01d1) - 55'(t00d2);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      sqr  <= 42'(q0) + 42'(q1) + 42'(q2);
      dneg <= dt[44];
      detu <= dt[44] ? 45'(-dt) : 45'(dt);
      neg0 <= e0[54]; num0 <= e0[54] ? 55'(-e0) : 55'(e0);
      neg1 <= e1[54]; num1 <= e1[54] ? 55'(-e1) : 55'(e1);
      c5 <= c4;
    end
  end
  always_comb none5 = (sqr < 42'(thr)) || (detu == '0) || (detu < 45'(thr));

  // reciprocal array plus matching delay line
  logic [63:0] rcp;
  ppil_recip #(.W(64)) u_recip (
    .clk(clk), .en(en),
    .d((detu == '0) ? 64'd1 : 64'(detu)), .q(rcp)
  );

  typedef struct packed {
    logic [54:0] num0, num1;
    logic n0, n1, dn, none;
    logic signed [17:0] a0, a1, a2, b0, b1, b2;
    logic [59:0] c;
  } dly_t;
  dly_t dl [DL+1];
  logic signed [17:0] a_d [3:0][3], b_d [3:0][3];
  always_ff @(posedge clk) begin
    if (en) begin
      a_d[0] <= a; b_d[0] <= b;
      for (int k = 1; k < 4; k++) begin a_d[k] <= a_d[k-1]; b_d[k] <= b_d[k-1]; end
    end
  end
  always_comb begin
    dl[0] = '{num0, num1, neg0, neg1, dneg, none5,
              a_d[3][0], a_d[3][1], a_d[3][2], b_d[3][0], b_d[3][1], b_d[3][2],
              {c5[2], c5[1], c5[0]}};
  end
  for (genvar k = 0; k < DL; k++) begin : g_dl
    always_ff @(posedge clk) if (en) dl[k+1] <= dl[k];
  end
  dly_t r;
  assign r = dl[DL];

  // coefficient products, split into 32-bit partial products
  logic [63:0] p0ll, p0lh, p0hl, p0hh, p1ll, p1lh, p1hl, p1hh;
  logic [31:0] m0h, m1h;
  dly_t r1, r2, r3;
  always_comb begin
    m0h = 32'(r.num0[54:32]);
    m1h = 32'(r.num1[54:32]);
  end
  always_ff @(posedge clk) begin
    if (en) begin
      p0ll <= r.num0[31:0]*rcp[31:0]; p0lh <= r.num0[31:0]*rcp[63:32];
      p0hl <= m0h*rcp[31:0];          p0hh <= m0h*rcp[63:32];
      p1ll <= r.num1[31:0]*rcp[31:0]; p1lh <= r.num1[31:0]*rcp[63:32];
      p1hl <= m1h*rcp[31:0];          p1hh <= m1h*rcp[63:32];
      r1 <= r;
    end
  end

  logic [127:0] f0, f1;
  always_ff @(posedge clk) begin
    if (en) begin
      f0 <= 128'(p0ll) + (128'(p0lh) << 32) + (128'(p0hl) << 32) + (128'(p0hh) << 64);
      f1 <= 128'(p1ll) + (128'(p1lh) << 32) + (128'(p1hl) << 32) + (128'(p1hh) << 64);
      r2 <= r1;
    end
  end

  logic [43:0] q0m, q1m;
  logic signed [44:0] k0, k1;
  always_comb begin
    q0m = (f0[127:91] != '0) ? ppil_pkg::COEF_MAX : f0[90:47];
    q1m = (f1[127:91] != '0) ? ppil_pkg::COEF_MAX : f1[90:47];
  end
  always_ff @(posedge clk) begin
    if (en) begin
      k0 <= (r2.n0 != r2.dn) ? -45'(q0m) : 45'(q0m);
      k1 <= (r2.n1 != r2.dn) ? -45'(q1m) : 45'(q1m);
      r3 <= r2;
    end
  end

  // point products: 45x18 cut into two halves
  logic signed [40:0] ph [2][3];
  logic [39:0]        pl [2][3];
  dly_t r4;
  logic signed [17:0] av [3], bv [3];
  always_comb begin
    av[0] = r3.a0; av[1] = r3.a1; av[2] = r3.a2;
    bv[0] = r3.b0; bv[1] = r3.b1; bv[2] = r3.b2;
  end
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ph[0][i] <= 41'($signed(k0[44:22]) * av[i]);
        pl[0][i] <= 40'($signed({1'b0, k0[21:0]}) * av[i]);
        ph[1][i] <= 41'($signed(k1[44:22]) * bv[i]);
        pl[1][i] <= 40'($signed({1'b0, k1[21:0]}) * bv[i]);
      end
      r4 <= r3;
    end
  end

  logic signed [65:0] sm [3];
  logic [95:0] pt;
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sm[i] = (66'(ph[0][i]) <<< 22) + 66'($signed(pl[0][i]))
            + (66'(ph[1][i]) <<< 22) + 66'($signed(pl[1][i]));
    end
  end

  logic signed [49:0] sh [3];
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      sh[i] = sm[i][65:16];
      if (r4.none) pt[32*i +: 32] = '0;
      else if (sh[i] > 50'sd2147483647) pt[32*i +: 32] = 32'h7FFF_FFFF;
      else if (sh[i] < -50'sd2147483648) pt[32*i +: 32] = 32'h8000_0000;
      else pt[32*i +: 32] = sh[i][31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_tdata <= {4'd0, r4.c, pt};
      m_tuser <= r4.none;
    end
  end

  `PPIL_ASSERT_IMPL(a_stall_hold, clk, rst, m_tvalid && !m_tready |=> m_tvalid)
  `PPIL_ASSERT_IMPL(a_none_zero, clk, rst, m_tvalid && m_tuser |-> m_tdata[95:0] == '0)
  `PPIL_ASSERT_NORST(a_rst_clear, clk, rst |=> !m_tvalid)
endmodule
`default_nettype wire

// File: dv/tb_plane_plane_intersection_line_top.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_plane_plane_intersection_line_top;

  typedef struct {
    logic signed [17:0] n1 [3];
    logic signed [31:0] d1;
    logic signed [17:0] n2 [3];
    logic signed [31:0] d2;
  } planes_t;

  typedef struct {
    logic               status;
    logic signed [31:0] pnt [3];
    logic signed [19:0] dir [3];
  } line_t;

  typedef struct {
    planes_t pl;
    logic    known;
    line_t   ln;
  } row_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [31:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [175:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic         m_tuser;

  plane_plane_intersection_line_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  logic [31:0] thresh = ppil_pkg::THRESH_RESET;
  line_t       pending_lines [$];
  int          errors = 0;
  int          words_in = 0;
  int          words_out = 0;
  int          no_line_cnt = 0;
  int          idle_cycles = 0;
  bit          long_hold = 1'b0;
  bit          done = 1'b0;

  function automatic logic signed [63:0] floor16(logic signed [63:0] v);
    return v >>> 16;
  endfunction

  function automatic logic signed [63:0] scale_coef(logic signed [63:0] num,
                                                    logic [63:0] recip, bit det_neg);
    logic [63:0]  mag;
    logic [127:0] prod;
    logic [63:0]  q;
    mag = num[63] ? 64'(-num) : 64'(num);
    prod = mag * recip;
    if (prod[127:64] >= (64'd1 << 27)) q = {20'd0, ppil_pkg::COEF_MAX};
    else q = 64'(prod >> 47);
    return (num[63] != det_neg) ? -$signed(q) : $signed(q);
  endfunction

  function automatic logic signed [31:0] clamp32(logic signed [63:0] v);
    if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic line_t solve_line(planes_t p, logic [31:0] th);
    line_t r;
    logic signed [63:0] a [3], b [3], c [3];
    logic signed [63:0] sq, n00, n01, n11, det, c0, c1;
    logic [63:0] det_u, recip;
    for (int i = 0; i < 3; i++) begin
      a[i] = p.n1[i];
      b[i] = p.n2[i];
      r.pnt[i] = '0;
    end
    c[0] = floor16(a[1] * b[2] - a[2] * b[1]);
    c[1] = floor16(a[2] * b[0] - a[0] * b[2]);
    c[2] = floor16(a[0] * b[1] - a[1] * b[0]);
    sq = c[0] * c[0] + c[1] * c[1] + c[2] * c[2];
    n00 = floor16(a[0] * a[0] + a[1] * a[1] + a[2] * a[2]);
    n01 = floor16(a[0] * b[0] + a[1] * b[1] + a[2] * b[2]);
    n11 = floor16(b[0] * b[0] + b[1] * b[1] + b[2] * b[2]);
    det = n00 * n11 - n01 * n01;
    r.status = (64'(sq) < {32'd0, th});
    if (!r.status) begin
      det_u = det[63] ? 64'(-det) : 64'(det);
      if (det_u == 0 || det_u < {32'd0, th}) r.status = 1'b1;
      else begin
        recip = (64'd1 << 63) / det_u;
        c0 = scale_coef(n01 * 64'(p.d2) - n11 * 64'(p.d1), recip, det[63]);
        c1 = scale_coef(n01 * 64'(p.d1) - n00 * 64'(p.d2), recip, det[63]);
        for (int i = 0; i < 3; i++) r.pnt[i] = clamp32(floor16(c0 * a[i] + c1 * b[i]));
      end
    end
    for (int i = 0; i < 3; i++) r.dir[i] = c[i][19:0];
    return r;
  endfunction

  function automatic bit lines_differ(line_t x, line_t y);
    bit diff;
    diff = (x.status != y.status);
    for (int i = 0; i < 3; i++) begin
      if (x.pnt[i] != y.pnt[i] || x.dir[i] != y.dir[i]) diff = 1'b1;
    end
    return diff;
  endfunction

  function automatic logic [175:0] pack_planes(planes_t p);
    return {4'd0, p.d2, p.n2[2], p.n2[1], p.n2[0], p.d1, p.n1[2], p.n1[1], p.n1[0]};
  endfunction

  function automatic planes_t mk(int ax, int ay, int az, int d1,
                                 int bx, int by, int bz, int d2);
    planes_t p;
    p.n1[0] = 18'(ax); p.n1[1] = 18'(ay); p.n1[2] = 18'(az); p.d1 = d1;
    p.n2[0] = 18'(bx); p.n2[1] = 18'(by); p.n2[2] = 18'(bz); p.d2 = d2;
    return p;
  endfunction

  function automatic planes_t rand_planes(int mode);
    planes_t p;
    for (int i = 0; i < 3; i++) begin
      p.n1[i] = 18'($urandom);
      p.n2[i] = 18'($urandom);
      if (mode == 1) begin
        p.n1[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
        p.n2[i] = 18'($signed($urandom_range(0, 131072)) - 65536);
      end
    end
    if (mode == 2) begin
      p.n2 = p.n1;
      if ($urandom_range(0, 1)) p.n2[$urandom_range(0, 2)] ^= 18'($urandom_range(1, 3));
    end
    p.d1 = $urandom;
    p.d2 = $urandom;
    if (mode == 1) begin
      p.d1 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
      p.d2 = $signed($urandom_range(0, 1 << 22)) - (1 << 21);
    end
    return p;
  endfunction

  task automatic send_planes(planes_t p, int gap);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= pack_planes(p);
    s_tvalid <= 1'b1;
    pending_lines.push_back(solve_line(p, thresh));
    do @(posedge clk); while (!s_tready);
    words_in++;
  endtask

  task automatic send_row(row_t r);
    line_t want;
    want = solve_line(r.pl, thresh);
    if (r.known && lines_differ(want, r.ln)) begin
      $error("table row disagrees with predicted line");
      errors++;
    end
    send_planes(r.pl, $urandom_range(0, 3));
  endtask

  task automatic drain_then_write(logic [31:0] value);
    s_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    thresh = value;
  endtask

  always @(posedge clk) begin
    line_t want, got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        idle_cycles <= 0;
        words_out++;
        got.status = m_tuser;
        got.pnt[0] = m_tdata[31:0];
        got.pnt[1] = m_tdata[63:32];
        got.pnt[2] = m_tdata[95:64];
        got.dir[0] = m_tdata[115:96];
        got.dir[1] = m_tdata[135:116];
        got.dir[2] = m_tdata[155:136];
        if (pending_lines.size() == 0) begin
          $error("unexpected result word");
          errors++;
        end else begin
          want = pending_lines.pop_front();
          if (got.status) no_line_cnt++;
          if (got.status != want.status) begin
            $error("status: expected %0d actual %0d", want.status, got.status);
            errors++;
          end
          for (int i = 0; i < 3; i++) begin
            if (got.pnt[i] != want.pnt[i]) begin
              $error("point[%0d]: expected %0d actual %0d", i, want.pnt[i], got.pnt[i]);
              errors++;
            end
            if (got.dir[i] != want.dir[i]) begin
              $error("direction[%0d]: expected %0d actual %0d", i, want.dir[i], got.dir[i]);
              errors++;
            end
          end
        end
      end else if (s_tvalid && s_tready) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    int gap;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    forever begin
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (300) @(posedge clk);
        long_hold = 1'b0;
      end
      gap = $urandom_range(0, 3);
      if ($urandom_range(0, 7) == 0) gap = 0;
      if (gap != 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (!done && idle_cycles > 2000) begin
        $display("plane_plane_intersection_line_top test failed");
        $finish;
      end
    end
  end

  initial begin
    row_t table_rows [$];
    row_t r;
    line_t z;
    logic [31:0] settings [5];
    settings = '{32'd0, 32'hFFFFFFFF, 32'd1, 32'd65536, 32'h80000000};
    z.status = 1'b1;
    for (int i = 0; i < 3; i++) begin
      z.pnt[i] = '0;
      z.dir[i] = '0;
    end
    r.known = 1'b1; r.ln = z;
    r.pl = mk(0, 0, 0, 0, 0, 0, 0, 0); table_rows.push_back(r);
    r.pl = mk(65536, 0, 0, 100, 65536, 0, 0, -100); table_rows.push_back(r);
    r.pl = mk(-131072, -131072, -131072, 32'h7FFFFFFF, -131072, -131072, -131072,
              32'h80000000);
    table_rows.push_back(r);
    r.known = 1'b0;
    r.pl = mk(65536, 0, 0, 65536, 0, 65536, 0, -65536); table_rows.push_back(r);
    r.pl = mk(0, 0, 65536, 0, 65536, 0, 0, 0); table_rows.push_back(r);
    r.pl = mk(131071, 0, 0, 32'h7FFFFFFF, 0, 131071, 0, 32'h80000000);
    table_rows.push_back(r);
    r.pl = mk(-131072, 0, 0, 32'h80000000, 0, 0, -131072, 32'h7FFFFFFF);
    table_rows.push_back(r);
    r.pl = mk(131071, 131071, 131071, 0, -131072, 131071, -131072, 12345);
    table_rows.push_back(r);
    r.pl = mk(65536, 0, 0, 32'h7FFFFFFF, 65536, 1, 0, 32'h80000000);
    table_rows.push_back(r);
    r.pl = mk(65536, 0, 0, 0, 65536, 40, 0, 65536); table_rows.push_back(r);
    r.pl = mk(1, 1, 1, 1, -1, 1, -1, -1); table_rows.push_back(r);
    r.pl = mk(46341, 46341, 0, -70000, -46341, 46341, 0, 80000); table_rows.push_back(r);
    r.pl = mk(65536, 65536, 0, 5, 65536, 65535, 0, -5); table_rows.push_back(r);

    @(negedge rst);
    foreach (table_rows[i]) send_row(table_rows[i]);
    s_tvalid <= 1'b0;
    while (pending_lines.size() != 0) @(posedge clk);

    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) drain_then_write(settings[ph - 1]);
      for (int k = 0; k < 205; k++) begin
        if (ph == 2 && k == 50) long_hold = 1'b1;
        send_planes(rand_planes($urandom_range(0, 9) < 6 ? 1 : ($urandom_range(0, 1) ? 0 : 2)),
                    (k % 40 < 8) ? 0 : $urandom_range(0, 3));
        if (ph == 3 && k == 100) begin
          s_tvalid <= 1'b0;
          while (pending_lines.size() != 0) @(posedge clk);
        end
      end
    end
    drain_then_write(ppil_pkg::THRESH_RESET);
    for (int k = 0; k < 20; k++) send_planes(rand_planes(1), $urandom_range(0, 3));
    s_tvalid <= 1'b0;

    while (pending_lines.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    done = 1'b1;
    $display("Sent %0d plane pairs, checked %0d lines (%0d without intersection)",
             words_in, words_out, no_line_cnt);
    $display("Thresholds covered: reset, zero, all ones, one, 1.0 and 2^31");
    if (errors == 0 && pending_lines.size() == 0) begin
      $display("plane_plane_intersection_line_top test passed");
    end else begin
      $display("plane_plane_intersection_line_top test failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
